// ===== design/vdh_pkg.sv =====
// ----------------------------------------------------------------------------
// v-disparity histogram package
// Field widths, function codes and fixed constants of the histogram core.
// ----------------------------------------------------------------------------
package vdh_pkg;

  // Field widths of the request and response transfers and of a histogram counter.
  localparam int FUNC_W  = 2;
  localparam int ROW_W   = 9;
  localparam int DISP_W  = 8;
  localparam int COUNT_W = 11;
  localparam int VAL_W   = 8;

  // Function codes of a request.
  localparam logic [FUNC_W-1:0] FUNC_PIXEL = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Disparities that carry no depth information.
  localparam logic [DISP_W-1:0] DISP_NONE    = 8'd0;
  localparam logic [DISP_W-1:0] DISP_INVALID = 8'd255;

  // Saturation limit of one histogram counter.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  // Full scale of a normalised count.
  localparam int NORM_SCALE = 255;

endpackage

// ===== design/vdh_if.sv =====
// ----------------------------------------------------------------------------
// v-disparity histogram channels
// Valid/ready channels for requests and for column peak responses.
// ----------------------------------------------------------------------------
interface vdh_in_if;
  logic                        valid;
  logic                        ready;
  logic [vdh_pkg::FUNC_W-1:0]  func;
  logic [vdh_pkg::ROW_W-1:0]   row;
  logic [vdh_pkg::DISP_W-1:0]  disparity;

  modport source (output valid, output func, output row, output disparity, input ready);
  modport sink   (input valid, input func, input row, input disparity, output ready);
endinterface

interface vdh_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [vdh_pkg::ROW_W-1:0]   peak_row;
  logic [vdh_pkg::VAL_W-1:0]   peak_value;

  modport source (output valid, output found, output peak_row, output peak_value,
                  input ready);
  modport sink   (input valid, input found, input peak_row, input peak_value,
                  output ready);
endinterface

// ===== design/v_disparity_histogram_peaks_core.sv =====
// Pixels: one transfer per cycle while idle; each count is written back in the next cycle.
// Query: up to two row scans over min(rows_in_use, ROWS) rows through the single read
//   port of the count RAM, with a bit-serial divider between them.
// Clear: one RAM word per cycle over all 2**(clog2(ROWS)+8) words (131072 at ROWS = 512).
// Reset: asynchronous, active low; the same clearing sweep runs after reset and no request
//   is taken until it ends. Configuration writes are taken at all times.
// ----------------------------------------------------------------------------
// v-disparity histogram core
// Counts pixels per row and disparity in a RAM, keeps the running maximum
// and returns the normalised peak row of a queried disparity column.
// ----------------------------------------------------------------------------
module v_disparity_histogram_peaks_core #(
  parameter int ROWS = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vdh_in_if.sink      req_i,
  vdh_out_if.source   rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CountW = vdh_pkg::COUNT_W;
  localparam int ValW   = vdh_pkg::VAL_W;
  localparam int RowW   = vdh_pkg::ROW_W;
  localparam int DispW  = vdh_pkg::DISP_W;
  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW     = RW + DispW;
  localparam int MemDepth = 2 ** AW;
  localparam int ExtW   = (RW > RowW) ? RW : RowW;
  localparam int CntW   = $clog2(ROWS + 1);
  localparam int NumW   = CountW + ValW;
  localparam int DcW    = $clog2(NumW + 1);
  localparam int KW     = ValW + 1 + CountW;
  localparam logic [KW-1:0] TwiceScale = KW'(2 * vdh_pkg::NORM_SCALE);
  localparam logic [AW-1:0] LastAddr   = AW'(MemDepth - 1);

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_ROWS      = 1'b1;
  localparam logic [7:0] THRESH_RESET = 8'd5;
  localparam logic [9:0] ROWS_RESET   = 10'd512;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN1 = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_KMUL  = 3'd5;
  localparam logic [2:0] S_SCAN2 = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [7:0]        thr_q;
  logic [9:0]        riu_q;
  logic [CountW-1:0] max_q, max_d;

  logic              s1_valid_q, s1_valid_d;
  logic [AW-1:0]     s1_addr_q;
  logic              wb_valid_q;
  logic [AW-1:0]     wb_addr_q;
  logic [CountW-1:0] wb_data_q;

  logic [AW-1:0]     clr_addr_q, clr_addr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              rd_pend_q, rd_pend_d;
  logic [RW-1:0]     dat_row_q, dat_row_d;
  logic [DispW-1:0]  disp_q, disp_d;
  logic [CountW-1:0] cmax_q, cmax_d;
  logic [NumW-1:0]   quo_q, quo_d;
  logic [CountW:0]   rem_q, rem_d;
  logic [DcW-1:0]    dcnt_q, dcnt_d;
  logic [ValW-1:0]   val_q, val_d;
  logic [KW-1:0]     k_q, k_d;
  logic [RW-1:0]     best_row_q, best_row_d;

  logic              out_valid_q, out_valid_d;
  logic              out_found_q;
  logic [RowW-1:0]   out_row_q;
  logic [ValW-1:0]   out_val_q;
  logic              out_load;

  logic              acc;
  logic              pix_ok;
  logic [ExtW-1:0]   row_ext;
  logic [AW-1:0]     pix_addr;
  logic [CntW-1:0]   lim;
  logic              scan_issue;
  logic [CountW-1:0] cur;
  logic [CountW-1:0] inc;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CountW-1:0] ram_wdata, ram_rdata;
  logic [CountW:0]   trial;
  logic              trial_ge;
  logic [CountW:0]   rem2;
  logic              round_up;
  logic [ValW:0]     rounded;
  logic [ValW:0]     odd_val;
  logic [KW-1:0]     scaled;
  logic              hit;
  logic              cfg_wr;

  // Configuration port.
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ROWS) ? {22'b0, riu_q} : {24'b0, thr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RESET;
      riu_q <= ROWS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_THRESHOLD) begin
        thr_q <= pwdata[7:0];
      end else begin
        riu_q <= pwdata[9:0];
      end
    end
  end

  // Request decode.
  assign req_i.ready = (state_q == S_IDLE);
  assign acc         = req_i.valid && req_i.ready;
  assign row_ext     = ExtW'(req_i.row);
  assign pix_addr    = {row_ext[RW-1:0], req_i.disparity};
  assign pix_ok      = acc && (req_i.func == vdh_pkg::FUNC_PIXEL)
                       && (req_i.disparity != vdh_pkg::DISP_NONE)
                       && (req_i.disparity != vdh_pkg::DISP_INVALID)
                       && ({23'b0, req_i.row} < 32'(ROWS));

  assign lim = (32'(riu_q) < 32'(ROWS)) ? CntW'(riu_q) : CntW'(ROWS);
  assign scan_issue = ((state_q == S_SCAN1) || (state_q == S_SCAN2)) && (cnt_q != lim);

  // A pixel read captured at the same edge as the previous write-back sees the
  // old word, so the written count is forwarded.
  assign cur = (wb_valid_q && (wb_addr_q == s1_addr_q)) ? wb_data_q : ram_rdata;
  assign inc = (cur == vdh_pkg::COUNT_MAX) ? cur : cur + CountW'(1);

  assign ram_re    = pix_ok || scan_issue;
  assign ram_raddr = pix_ok ? pix_addr : {cnt_q[RW-1:0], disp_q};
  assign ram_we    = s1_valid_q || (state_q == S_CLEAR);
  assign ram_waddr = s1_valid_q ? s1_addr_q : clr_addr_q;
  assign ram_wdata = s1_valid_q ? inc : '0;

  vdh_ram #(
    .Width (CountW),
    .Depth (MemDepth)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Divider step, rounding and the scan threshold.
  assign trial    = {rem_q[CountW-1:0], quo_q[NumW-1]};
  assign trial_ge = (trial >= {1'b0, max_q});
  assign rem2     = {rem_q[CountW-1:0], 1'b0};
  assign round_up = (rem2 > {1'b0, max_q}) || ((rem2 == {1'b0, max_q}) && quo_q[0]);
  assign rounded  = {1'b0, quo_q[ValW-1:0]} + (ValW + 1)'(round_up);
  assign odd_val  = {val_q, 1'b0} - (ValW + 1)'(1);

  // A row reaches the peak value once 510*count clears (2*peak-1)*max; on an
  // exact tie, rounding half to even lifts it only when the peak is even.
  assign scaled = KW'(ram_rdata) * TwiceScale;
  assign hit    = rd_pend_q && ((scaled > k_q) || ((scaled == k_q) && !val_q[0]));

  assign out_load = (state_q == S_FIN) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d    = state_q;
    max_d      = max_q;
    s1_valid_d = pix_ok;
    clr_addr_d = clr_addr_q;
    cnt_d      = cnt_q;
    rd_pend_d  = 1'b0;
    dat_row_d  = dat_row_q;
    disp_d     = disp_q;
    cmax_d     = cmax_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    dcnt_d     = dcnt_q;
    val_d      = val_q;
    k_d        = k_q;
    best_row_d = best_row_q;

    if (s1_valid_q && (inc > max_q)) begin
      max_d = inc;
    end

    if (scan_issue) begin
      cnt_d     = cnt_q + CntW'(1);
      rd_pend_d = 1'b1;
      dat_row_d = cnt_q[RW-1:0];
    end

    case (state_q)
      S_CLEAR: begin
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == LastAddr) begin
          max_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          case (req_i.func)
            vdh_pkg::FUNC_QUERY: begin
              cnt_d   = '0;
              cmax_d  = '0;
              disp_d  = req_i.disparity;
              state_d = S_SCAN1;
            end
            vdh_pkg::FUNC_CLEAR: begin
              clr_addr_d = '0;
              state_d    = S_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN1: begin
        if (rd_pend_q && (ram_rdata > cmax_q)) begin
          cmax_d = ram_rdata;
        end
        if (!scan_issue && !rd_pend_q) begin
          if ((max_q == '0) || (cmax_q == '0)) begin
            val_d      = '0;
            best_row_d = '0;
            state_d    = S_FIN;
          end else begin
            quo_d   = NumW'(cmax_q) * NumW'(vdh_pkg::NORM_SCALE);
            rem_d   = '0;
            dcnt_d  = DcW'(NumW);
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_d  = trial_ge ? (trial - {1'b0, max_q}) : trial;
        quo_d  = {quo_q[NumW-2:0], trial_ge};
        dcnt_d = dcnt_q - DcW'(1);
        if (dcnt_q == DcW'(1)) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        val_d   = rounded[ValW] ? {ValW{1'b1}} : rounded[ValW-1:0];
        state_d = S_KMUL;
      end
      S_KMUL: begin
        if (val_q == '0) begin
          best_row_d = '0;
          state_d    = S_FIN;
        end else begin
          k_d     = KW'(odd_val) * KW'(max_q);
          cnt_d   = '0;
          state_d = S_SCAN2;
        end
      end
      S_SCAN2: begin
        if (hit) begin
          best_row_d = dat_row_q;
          state_d    = S_FIN;
        end else if (!scan_issue && !rd_pend_q) begin
          best_row_d = '0;
          state_d    = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      max_q       <= '0;
      s1_valid_q  <= 1'b0;
      wb_valid_q  <= 1'b0;
      rd_pend_q   <= 1'b0;
      cnt_q       <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      max_q       <= max_d;
      s1_valid_q  <= s1_valid_d;
      wb_valid_q  <= s1_valid_q;
      rd_pend_q   <= rd_pend_d;
      cnt_q       <= cnt_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q  <= pix_addr;
    wb_addr_q  <= s1_addr_q;
    wb_data_q  <= inc;
    dat_row_q  <= dat_row_d;
    disp_q     <= disp_d;
    cmax_q     <= cmax_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    val_q      <= val_d;
    k_q        <= k_d;
    best_row_q <= best_row_d;
    if (out_load) begin
      out_found_q <= (val_q > thr_q);
      out_row_q   <= RowW'(best_row_q);
      out_val_q   <= val_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.found      = out_found_q;
  assign rsp_o.peak_row   = out_row_q;
  assign rsp_o.peak_value = out_val_q;

`ifndef SYNTH
  // The pixel write-back and the clearing sweep share the RAM write port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_valid_q && (state_q == S_CLEAR)))
    else $error("pixel write-back collides with clearing sweep");

  // The running maximum covers every count that has been written back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> (max_q >= $past(ram_wdata)))
    else $error("running maximum below a written count");

  // The quotient of count*255 by the maximum never exceeds full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND) |-> (quo_q[NumW-1:ValW] == '0))
    else $error("normalised quotient out of range");

  // A response is only raised from the final step of a query.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FIN))
    else $error("response raised outside a query");

  // The found flag agrees with the reported peak and the threshold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.found == (rsp_o.peak_value > thr_q)))
    else $error("found flag inconsistent with peak value");
`endif

endmodule

// ===== design/vdh_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered and a read of
// the address being written returns the old contents.
// ----------------------------------------------------------------------------
module vdh_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/v_disparity_histogram_peaks_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// v-disparity histogram core testbench
// Drives pixel, query, clear and unused requests through the request channel,
// programs the threshold and row count over APB, and checks every column peak
// response against a cycle-free prediction of the histogram and its maximum.
// ----------------------------------------------------------------------------
module v_disparity_histogram_peaks_core_tb;

  localparam int          CLK_PERIOD  = 20;
  localparam int          ROWS        = 512;
  localparam int          BINS        = 256;
  localparam int unsigned STALL_LIMIT = 524288;
  localparam int          HOLD_CYCLES = 3000;

  localparam int FUNC_W     = vdh_pkg::FUNC_W;
  localparam int ROW_W      = vdh_pkg::ROW_W;
  localparam int DISP_W     = vdh_pkg::DISP_W;
  localparam int COUNT_W    = vdh_pkg::COUNT_W;
  localparam int VAL_W      = vdh_pkg::VAL_W;
  localparam int NORM_SCALE = vdh_pkg::NORM_SCALE;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED   = 2'd3;
  localparam logic [2:0]        REG_THRESHOLD = 3'd0;
  localparam logic [2:0]        REG_ROWS      = 3'd4;

  typedef struct packed {
    logic              found;
    logic [ROW_W-1:0]  peak_row;
    logic [VAL_W-1:0]  peak_value;
  } col_peak_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  vdh_in_if  req_if ();
  vdh_out_if rsp_if ();

  v_disparity_histogram_peaks_core #(
    .ROWS (ROWS)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted state of the block.
  bit [COUNT_W-1:0] count_mem [ROWS*BINS];
  bit [COUNT_W-1:0] max_count;
  bit [7:0]         thr_reg;
  bit [9:0]         scan_rows;

  col_peak_t   pending_peaks [$];
  int          err_count;
  int          src_idle_pct;
  int          snk_idle_pct;
  int          hold_left;
  int          clears_left;
  int unsigned stall_cycles;

  initial clk_i = 1'b0;
  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  // round(cnt*255/maxv) with ties to even; maxv is non-zero.
  function automatic int unsigned norm_count(input int unsigned cnt,
                                             input int unsigned maxv);
    int unsigned num, q, r;
    num = cnt * NORM_SCALE;
    q   = num / maxv;
    r   = num % maxv;
    if (2 * r > maxv || (2 * r == maxv && (q % 2) == 1)) q++;
    if (q > NORM_SCALE) q = NORM_SCALE;
    return q;
  endfunction

  function automatic col_peak_t column_peak(input logic [DISP_W-1:0] disp);
    int unsigned limit, best_val, best_row, v;
    col_peak_t   res;
    limit    = (scan_rows > ROWS) ? ROWS : scan_rows;
    best_val = 0;
    best_row = 0;
    if (max_count != 0) begin
      for (int unsigned r = 0; r < limit; r++) begin
        v = norm_count(count_mem[r*BINS + disp], max_count);
        if (v > best_val) begin
          best_val = v;
          best_row = r;
        end
      end
    end
    res.found      = (best_val > thr_reg);
    res.peak_row   = best_row[ROW_W-1:0];
    res.peak_value = best_val[VAL_W-1:0];
    return res;
  endfunction

  // Appends a predicted peak to the tail of the pending list.
  function automatic void queue_peak(input col_peak_t peak);
    pending_peaks.insert(pending_peaks.size(), peak);
  endfunction

  // Offers one request and updates the prediction once it is transferred.
  // valid is left high so that back-to-back requests need no extra cycle.
  task automatic send_request(input logic [FUNC_W-1:0] func,
                              input logic [ROW_W-1:0]  row,
                              input logic [DISP_W-1:0] disp);
    int unsigned idx;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.func      <= func;
    req_if.row       <= row;
    req_if.disparity <= disp;
    do @(posedge clk_i); while (!req_if.ready);
    case (func)
      vdh_pkg::FUNC_PIXEL: begin
        if (disp != vdh_pkg::DISP_NONE && disp != vdh_pkg::DISP_INVALID && row < ROWS) begin
          idx = row * BINS + disp;
          if (count_mem[idx] != vdh_pkg::COUNT_MAX) count_mem[idx]++;
          if (count_mem[idx] > max_count) max_count = count_mem[idx];
        end
      end
      vdh_pkg::FUNC_QUERY: queue_peak(column_peak(disp));
      vdh_pkg::FUNC_CLEAR: begin
        foreach (count_mem[i]) count_mem[i] = '0;
        max_count = '0;
      end
      default: ;
    endcase
  endtask

  // Lowers valid and waits until every predicted peak has come back.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] mask;
    mask = (addr == REG_ROWS) ? 32'h3FF : 32'hFF;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == REG_ROWS) scan_rows = data[9:0];
    else                  thr_reg   = data[7:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & mask) !== (data & mask)) begin
      $display("%0t: register %0d read-back expected %0h, actual %0h",
               $time, addr, data & mask, prdata & mask);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_directed();
    send_request(vdh_pkg::FUNC_QUERY, 9'd0, 8'd1);
    send_request(vdh_pkg::FUNC_PIXEL, 9'd0, vdh_pkg::DISP_NONE);
    send_request(vdh_pkg::FUNC_PIXEL, 9'd511, vdh_pkg::DISP_INVALID);
    send_request(FUNC_UNUSED, 9'd511, 8'd255);
    send_request(FUNC_UNUSED, 9'd0, 8'd1);
    send_request(vdh_pkg::FUNC_PIXEL, 9'd511, 8'd254);
    send_request(vdh_pkg::FUNC_PIXEL, 9'd0, 8'd1);
    send_request(vdh_pkg::FUNC_PIXEL, 9'd0, 8'd1);
    send_request(vdh_pkg::FUNC_PIXEL, 9'd3, 8'd1);
    send_request(vdh_pkg::FUNC_PIXEL, 9'd3, 8'd1);
    send_request(vdh_pkg::FUNC_PIXEL, 9'd7, 8'd128);
    // Equal peaks in rows 0 and 3 must report row 0; a half count rounds to even.
    send_request(vdh_pkg::FUNC_QUERY, 9'd0, 8'd1);
    send_request(vdh_pkg::FUNC_QUERY, 9'd0, 8'd254);
    send_request(vdh_pkg::FUNC_QUERY, 9'd0, 8'd128);
    send_request(vdh_pkg::FUNC_QUERY, 9'd0, 8'd0);
    send_request(vdh_pkg::FUNC_QUERY, 9'd0, 8'd255);
    wait_drained();
    write_reg(REG_ROWS, 32'd0);
    send_request(vdh_pkg::FUNC_QUERY, 9'd0, 8'd1);
    wait_drained();
    write_reg(REG_ROWS, 32'd1023);
    send_request(vdh_pkg::FUNC_QUERY, 9'd0, 8'd254);
    wait_drained();
    write_reg(REG_ROWS, 32'd1);
    send_request(vdh_pkg::FUNC_QUERY, 9'd0, 8'd128);
    wait_drained();
    write_reg(REG_ROWS, 32'd512);
    write_reg(REG_THRESHOLD, 32'd255);
    send_request(vdh_pkg::FUNC_QUERY, 9'd0, 8'd1);
    wait_drained();
    write_reg(REG_THRESHOLD, 32'd0);
    send_request(vdh_pkg::FUNC_QUERY, 9'd0, 8'd254);
    send_request(vdh_pkg::FUNC_CLEAR, 9'd0, 8'd0);
    send_request(vdh_pkg::FUNC_QUERY, 9'd0, 8'd1);
    wait_drained();
    write_reg(REG_THRESHOLD, 32'd5);
  endtask

  // Bursts of pixels on a few hot columns with queries in between; each burst
  // runs under a fresh threshold and row count.
  task automatic test_random(input int src_pct, input int snk_pct, input int n_items);
    int          sent, burst_len, rspan, k;
    logic [9:0]  rows;
    logic [7:0]  thr;
    logic [7:0]  hot [3];
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0:       rows = 10'd0;
        1:       rows = 10'd512;
        2:       rows = 10'd1023;
        3:       rows = 10'($urandom_range(1023));
        default: rows = 10'($urandom_range(48, 1));
      endcase
      case ($urandom_range(7))
        0:       thr = 8'd0;
        1:       thr = 8'd255;
        2:       thr = 8'($urandom_range(255));
        default: thr = 8'($urandom_range(40));
      endcase
      write_reg(REG_ROWS, {22'd0, rows});
      write_reg(REG_THRESHOLD, {24'd0, thr});
      foreach (hot[i]) hot[i] = 8'($urandom_range(254, 1));
      rspan = (rows == 0) ? 1 : ((rows > ROWS) ? ROWS : rows);
      burst_len = $urandom_range(60, 20);
      for (int n = 0; n < burst_len; n++) begin
        k = $urandom_range(99);
        if (k < 70) begin
          send_request(vdh_pkg::FUNC_PIXEL, ROW_W'($urandom_range(rspan - 1)),
                       hot[$urandom_range(2)]);
        end else if (k < 78) begin
          send_request(vdh_pkg::FUNC_PIXEL, ROW_W'($urandom_range(511)),
                       DISP_W'($urandom_range(255)));
        end else if (k < 93) begin
          if ($urandom_range(4) != 0)
            send_request(vdh_pkg::FUNC_QUERY, ROW_W'($urandom_range(511)),
                         hot[$urandom_range(2)]);
          else
            send_request(vdh_pkg::FUNC_QUERY, ROW_W'($urandom_range(511)),
                         DISP_W'($urandom_range(255)));
        end else if (k < 98 || clears_left == 0) begin
          send_request(FUNC_UNUSED, ROW_W'($urandom_range(511)),
                       DISP_W'($urandom_range(255)));
        end else begin
          clears_left--;
          send_request(vdh_pkg::FUNC_CLEAR, ROW_W'($urandom_range(511)),
                       DISP_W'($urandom_range(255)));
        end
      end
      send_request(vdh_pkg::FUNC_QUERY, 9'd0, hot[0]);
      wait_drained();
      sent += burst_len + 1;
    end
  endtask

  // The receiver holds off while queries keep coming, so the core fills up.
  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_reg(REG_ROWS, 32'd4);
    write_reg(REG_THRESHOLD, 32'd0);
    repeat (6) send_request(vdh_pkg::FUNC_PIXEL, ROW_W'($urandom_range(3)),
                            DISP_W'($urandom_range(12, 10)));
    hold_left = HOLD_CYCLES;
    for (int n = 0; n < 40; n++) begin
      if (n % 4 == 3)
        send_request(vdh_pkg::FUNC_PIXEL, ROW_W'($urandom_range(3)),
                     DISP_W'($urandom_range(12, 10)));
      else
        send_request(vdh_pkg::FUNC_QUERY, 9'd0, DISP_W'($urandom_range(12, 10)));
    end
    wait_drained();
  endtask

  // Response ready: random idling, or a counted hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left--;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    col_peak_t want;
    if (rsp_if.valid && rsp_if.ready) begin
      if (pending_peaks.size() == 0) begin
        $display("%0t: unexpected peak found=%0d row=%0d value=%0d", $time,
                 rsp_if.found, rsp_if.peak_row, rsp_if.peak_value);
        err_count++;
      end else begin
        want = pending_peaks.pop_front();
        if (rsp_if.found !== want.found || rsp_if.peak_row !== want.peak_row ||
            rsp_if.peak_value !== want.peak_value) begin
          $display("%0t: peak expected %0d/%0d/%0d, actual %0d/%0d/%0d",
                   $time, want.found, want.peak_row, want.peak_value,
                   rsp_if.found, rsp_if.peak_row, rsp_if.peak_value);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer; a clear alone sweeps all 131072 RAM words.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_if.valid     = 1'b0;
    req_if.func      = '0;
    req_if.row       = '0;
    req_if.disparity = '0;
    rsp_if.ready     = 1'b0;
    err_count        = 0;
    src_idle_pct     = 0;
    snk_idle_pct     = 0;
    hold_left        = 0;
    clears_left      = 2;
    stall_cycles     = 0;
    max_count        = '0;
    thr_reg          = 8'd5;
    scan_rows        = 10'd512;
    foreach (count_mem[i]) count_mem[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random(29, 85, 580);
    test_random(85, 29, 580);
    test_random(0, 0, 580);
    test_backpressure();

    wait_drained();
    repeat (64) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
